// ----- design/weighted_centroid_quantile_sketch_assert.svh -----
// Assertion macros used by the sketch top level
`ifndef WEIGHTED_CENTROID_QUANTILE_SKETCH_ASSERT_SVH
`define WEIGHTED_CENTROID_QUANTILE_SKETCH_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WCQS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define WCQS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WCQS_ASSERT_IMP(lbl, ante, cons, msg)
`define WCQS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/wcqs_pkg.sv -----
// Shared types and constants of the quantile sketch
package wcqs_pkg;

  localparam int CapacityDef = 64;
  localparam int MeanW       = 32;
  localparam int WtW         = 48;
  localparam int SmpWtW      = 32;
  localparam int PctW        = 17;
  localparam int ModeW       = 2;
  localparam int InDataW     = 88;
  localparam int TotW        = WtW + 1;
  localparam int MulSplit    = 24;
  localparam int MulAW       = MeanW + 2;
  localparam int MulBW       = TotW - MulSplit;
  localparam int AccW        = 84;
  localparam int DivQW       = 32;
  localparam int DivNumW     = TotW + DivQW;
  localparam int TgtW        = WtW + PctW;
  localparam int EntW        = MeanW + WtW;

  localparam logic [ModeW-1:0] ModeStd  = 2'd1;
  localparam logic [ModeW-1:0] ModeAggr = 2'd2;

  localparam logic RegMode = 1'b0;
  localparam logic RegThr  = 1'b1;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_QSTART, OP_RD_IDX, OP_Q_EV, OP_GSTART, OP_G_EV, OP_G_DEC,
    OP_CSTD, OP_C_LD0, OP_C_EV, OP_MAC_T0, OP_MAC_T1, OP_MAC_M0, OP_MAC_M1,
    OP_MAC_M2, OP_MAC_M3, OP_DIV_START, OP_C_MRG, OP_C_WR, OP_C_FIN, OP_I_START,
    OP_RD_PREV, OP_I_SHIFT, OP_I_PUT, OP_S_START, OP_S_EV, OP_S_FIN
  } dp_op_e;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DISP, ST_Q_MUL, ST_Q_RD, ST_Q_EV, ST_G_START, ST_G_RD, ST_G_EV,
    ST_G_DEC, ST_C_SET, ST_C_RD0, ST_C_LD0, ST_C_RD, ST_C_EV, ST_C_T0, ST_C_T1,
    ST_C_TCHK, ST_C_M0, ST_C_M1, ST_C_M2, ST_C_M3, ST_C_DIV, ST_C_DIVW, ST_C_MRG,
    ST_C_WR, ST_C_FIN, ST_C_POST, ST_I_START, ST_I_CHK, ST_I_EV, ST_I_PUT,
    ST_S_START, ST_S_RD, ST_S_EV, ST_DONE
  } state_e;

  typedef struct packed {
    logic cmd;
    logic wzero;
    logic used_zero;
    logic full;
    logic idx_zero;
    logic idx_eq_used;
    logic idx_last;
    logic q_hit;
    logic i_ge;
    logic ok_nw;
    logic ok_w;
    logic use_w;
    logic div_busy;
  } dp_stat_t;

endpackage

// ----- design/wcqs_div.sv -----
// Restoring divider, one quotient bit per cycle
module wcqs_div import wcqs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [TotW-1:0]    den_i,
  output logic               busy_o,
  output logic [DivQW-1:0]   q_o
);

  localparam int CntW = $clog2(DivQW + 1);

  logic [CntW-1:0]  cnt_q;
  logic [TotW-1:0]  rem_q, den_q;
  logic [DivQW-1:0] low_q, q_q;
  logic [TotW:0]    r2;
  logic             ge;

  assign r2 = {rem_q, low_q[DivQW-1]};
  assign ge = r2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(DivQW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // numerator's top part is known to lie below the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[DivNumW-1:DivQW];
      low_q <= num_i[DivQW-1:0];
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? TotW'(r2 - {1'b0, den_q}) : r2[TotW-1:0];
      low_q <= {low_q[DivQW-2:0], 1'b0};
      q_q   <= {q_q[DivQW-2:0], ge};
    end
  end

  assign busy_o = cnt_q != '0;
  assign q_o    = q_q;

endmodule

// ----- design/wcqs_ctrl.sv -----
// Sequencer of the sketch: one item at a time
module wcqs_ctrl import wcqs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  input  logic             out_free_i,
  input  logic [ModeW-1:0] mode_i,
  input  dp_stat_t         stat_i,
  output logic             s_ready_o,
  output logic             out_load_o,
  output dp_op_e           op_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (s_valid_i) state_d = ST_DISP;
      ST_DISP: begin
        if (stat_i.cmd) begin
          state_d = stat_i.used_zero ? ST_DONE : ST_Q_MUL;
        end else if (stat_i.wzero) begin
          state_d = ST_DONE;
        end else if (!stat_i.full) begin
          state_d = ST_I_START;
        end else if (mode_i == ModeStd) begin
          state_d = ST_C_SET;
        end else if (mode_i == ModeAggr) begin
          state_d = ST_G_START;
        end else begin
          state_d = ST_S_START;
        end
      end
      ST_Q_MUL:   state_d = ST_Q_RD;
      ST_Q_RD:    state_d = ST_Q_EV;
      ST_Q_EV:    state_d = (stat_i.idx_last || stat_i.q_hit) ? ST_DONE : ST_Q_RD;
      ST_G_START: state_d = ST_G_RD;
      ST_G_RD:    state_d = ST_G_EV;
      ST_G_EV:    state_d = stat_i.idx_last ? ST_G_DEC : ST_G_RD;
      ST_G_DEC:   state_d = ST_C_RD0;
      ST_C_SET:   state_d = ST_C_RD0;
      ST_C_RD0:   state_d = ST_C_LD0;
      ST_C_LD0:   state_d = ST_C_RD;
      ST_C_RD:    state_d = ST_C_EV;
      ST_C_EV:    state_d = ST_C_T0;
      ST_C_T0: begin
        if (stat_i.use_w) begin
          state_d = ST_C_T1;
        end else begin
          state_d = stat_i.ok_nw ? ST_C_M0 : ST_C_WR;
        end
      end
      ST_C_T1:    state_d = ST_C_TCHK;
      ST_C_TCHK:  state_d = stat_i.ok_w ? ST_C_M0 : ST_C_WR;
      ST_C_M0:    state_d = ST_C_M1;
      ST_C_M1:    state_d = ST_C_M2;
      ST_C_M2:    state_d = ST_C_M3;
      ST_C_M3:    state_d = ST_C_DIV;
      ST_C_DIV:   state_d = ST_C_DIVW;
      ST_C_DIVW:  if (!stat_i.div_busy) state_d = ST_C_MRG;
      ST_C_MRG,
      ST_C_WR:    state_d = stat_i.idx_last ? ST_C_FIN : ST_C_RD;
      ST_C_FIN:   state_d = ST_C_POST;
      ST_C_POST:  state_d = stat_i.full ? ST_S_START : ST_I_START;
      ST_I_START: state_d = ST_I_CHK;
      ST_I_CHK:   state_d = stat_i.idx_zero ? ST_I_PUT : ST_I_EV;
      ST_I_EV:    state_d = stat_i.i_ge ? ST_I_CHK : ST_I_PUT;
      ST_I_PUT:   state_d = ST_S_START;
      ST_S_START: state_d = ST_S_RD;
      ST_S_RD:    state_d = stat_i.idx_eq_used ? ST_DONE : ST_S_EV;
      ST_S_EV:    state_d = ST_S_RD;
      ST_DONE:    if (out_free_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o  = 1'b0;
    out_load_o = 1'b0;
    op_o       = OP_NOP;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) op_o = OP_LOAD;
      end
      ST_Q_MUL:   op_o = OP_QSTART;
      ST_Q_RD,
      ST_G_RD,
      ST_C_RD0,
      ST_C_RD:    op_o = OP_RD_IDX;
      ST_Q_EV:    op_o = OP_Q_EV;
      ST_G_START: op_o = OP_GSTART;
      ST_G_EV:    op_o = OP_G_EV;
      ST_G_DEC:   op_o = OP_G_DEC;
      ST_C_SET:   op_o = OP_CSTD;
      ST_C_LD0:   op_o = OP_C_LD0;
      ST_C_EV:    op_o = OP_C_EV;
      ST_C_T0:    op_o = OP_MAC_T0;
      ST_C_T1:    op_o = OP_MAC_T1;
      ST_C_M0:    op_o = OP_MAC_M0;
      ST_C_M1:    op_o = OP_MAC_M1;
      ST_C_M2:    op_o = OP_MAC_M2;
      ST_C_M3:    op_o = OP_MAC_M3;
      ST_C_DIV:   op_o = OP_DIV_START;
      ST_C_MRG:   op_o = OP_C_MRG;
      ST_C_WR:    op_o = OP_C_WR;
      ST_C_FIN:   op_o = OP_C_FIN;
      ST_I_START: op_o = OP_I_START;
      ST_I_CHK:   op_o = stat_i.idx_zero ? OP_NOP : OP_RD_PREV;
      ST_I_EV:    op_o = stat_i.i_ge ? OP_I_SHIFT : OP_NOP;
      ST_I_PUT:   op_o = OP_I_PUT;
      ST_S_START: op_o = OP_S_START;
      ST_S_RD:    op_o = stat_i.idx_eq_used ? OP_S_FIN : OP_RD_IDX;
      ST_S_EV:    op_o = OP_S_EV;
      ST_DONE:    out_load_o = out_free_i;
      default:    op_o = OP_NOP;
    endcase
  end

endmodule

// ----- design/wcqs_dp.sv -----
// Datapath: centroid table, multiply-accumulate, divider, scan registers
module wcqs_dp import wcqs_pkg::*; #(
  parameter int CAPACITY = CapacityDef,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_op_e                  op_i,
  input  logic                    cmd_i,
  input  logic signed [MeanW-1:0] value_i,
  input  logic [SmpWtW-1:0]       weight_i,
  input  logic [PctW-1:0]         pct_i,
  input  logic [WtW-1:0]          thr_i,
  output dp_stat_t                stat_o,
  output logic signed [MeanW-1:0] ans_o,
  output logic                    acc_o,
  output logic [CW-1:0]           used_o,
  output logic [WtW-1:0]          ws_o
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CumW = WtW + AW + 1;
  localparam int CmpW = CumW + 16;
  localparam int GapW = MeanW + 1;

  function automatic logic [MeanW-1:0] absdiff(logic signed [MeanW-1:0] a,
                                               logic signed [MeanW-1:0] b);
    logic [MeanW:0] t;
    t = {a[MeanW-1], a} - {b[MeanW-1], b};
    return t[MeanW] ? MeanW'(-t) : t[MeanW-1:0];
  endfunction

  logic [EntW-1:0] mem [CAPACITY];

  logic                    cmd_q, acc_q, use_w_q, neg_q;
  logic signed [MeanW-1:0] val_q, ans_q, cm_q, em_q, prev_q;
  logic [SmpWtW-1:0]       wt_q;
  logic [PctW-1:0]         pct_q;
  logic [CW-1:0]           used_q, idx_q, n_q;
  logic [WtW-1:0]          ws_q, cw_q, ew_q, sum_q;
  logic [CumW-1:0]         cum_q;
  logic [TgtW-1:0]         tgt_q;
  logic [GapW-1:0]         gmin_q;
  logic [MeanW-1:0]        d_q;
  logic [TotW-1:0]         tot_q;
  logic signed [AccW-1:0]  mac_q;
  logic [EntW-1:0]         rd_q;

  logic signed [MeanW-1:0] rdm;
  logic [WtW-1:0]          rdw;
  logic                    rd_en, we;
  logic [AW-1:0]           raddr, waddr;
  logic [EntW-1:0]         wdata;
  logic [CumW-1:0]         cum_new;
  logic [MeanW-1:0]        dg;
  logic [TotW-1:0]         sum_new;

  logic signed [MulAW-1:0]       ma;
  logic [MulBW-1:0]              mb;
  logic                          mac_hi, mac_clr;
  logic signed [MulAW+MulBW:0]   prod;
  logic signed [AccW-1:0]        term;
  logic [AccW-1:0]               mag;
  logic                          div_busy;
  logic [DivQW-1:0]              div_q;

  assign rdm     = rd_q[EntW-1:WtW];
  assign rdw     = rd_q[WtW-1:0];
  assign cum_new = cum_q + CumW'(rdw);
  assign dg      = absdiff(rdm, prev_q);
  assign sum_new = {1'b0, sum_q} + {1'b0, rdw};

  // table ports
  always_comb begin
    rd_en = 1'b0;
    raddr = idx_q[AW-1:0];
    we    = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = rd_q;
    case (op_i)
      OP_RD_IDX:  rd_en = 1'b1;
      OP_RD_PREV: begin
        rd_en = 1'b1;
        raddr = AW'(idx_q - 1'b1);
      end
      OP_C_WR, OP_C_FIN: begin
        we    = 1'b1;
        waddr = n_q[AW-1:0];
        wdata = {cm_q, cw_q};
      end
      OP_I_SHIFT: we = 1'b1;
      OP_I_PUT: begin
        we    = 1'b1;
        wdata = {val_q, WtW'(wt_q)};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rd_q <= mem[raddr];
  end

  // shared multiplier: weight operands split at MulSplit
  always_comb begin
    ma      = '0;
    mb      = '0;
    mac_hi  = 1'b0;
    mac_clr = 1'b0;
    case (op_i)
      OP_MAC_T0: begin
        ma      = MulAW'(d_q);
        mb      = MulBW'(tot_q[MulSplit-1:0]);
        mac_clr = 1'b1;
      end
      OP_MAC_T1: begin
        ma     = MulAW'(d_q);
        mb     = tot_q[TotW-1:MulSplit];
        mac_hi = 1'b1;
      end
      OP_MAC_M0: begin
        ma      = MulAW'(cm_q);
        mb      = MulBW'(cw_q[MulSplit-1:0]);
        mac_clr = 1'b1;
      end
      OP_MAC_M1: begin
        ma     = MulAW'(cm_q);
        mb     = MulBW'(cw_q[WtW-1:MulSplit]);
        mac_hi = 1'b1;
      end
      OP_MAC_M2: begin
        ma = MulAW'(em_q);
        mb = MulBW'(ew_q[MulSplit-1:0]);
      end
      OP_MAC_M3: begin
        ma     = MulAW'(em_q);
        mb     = MulBW'(ew_q[WtW-1:MulSplit]);
        mac_hi = 1'b1;
      end
      default: mac_hi = 1'b0;
    endcase
  end

  assign prod = ma * $signed({1'b0, mb});
  assign term = mac_hi ? (AccW'(prod) <<< MulSplit) : AccW'(prod);
  assign mag  = mac_q[AccW-1] ? AccW'(-mac_q) : AccW'(mac_q);

  wcqs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(op_i == OP_DIV_START),
    .num_i  (mag[DivNumW-1:0]),
    .den_i  (tot_q),
    .busy_o (div_busy),
    .q_o    (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      ws_q   <= '0;
    end else begin
      case (op_i)
        OP_C_FIN: used_q <= n_q + 1'b1;
        OP_I_PUT: used_q <= used_q + 1'b1;
        OP_S_FIN: ws_q   <= sum_q;
        default:  used_q <= used_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_clr) begin
      mac_q <= term;
    end else if (op_i == OP_MAC_T1 || op_i == OP_MAC_M1 || op_i == OP_MAC_M2 ||
                 op_i == OP_MAC_M3) begin
      mac_q <= mac_q + term;
    end
    case (op_i)
      OP_LOAD: begin
        cmd_q <= cmd_i;
        val_q <= value_i;
        wt_q  <= weight_i;
        pct_q <= pct_i;
        ans_q <= '0;
        acc_q <= 1'b0;
      end
      OP_QSTART: begin
        tgt_q <= ws_q * pct_q;
        cum_q <= '0;
        idx_q <= '0;
      end
      OP_Q_EV: begin
        cum_q <= cum_new;
        ans_q <= rdm;
        idx_q <= idx_q + 1'b1;
      end
      OP_GSTART: begin
        idx_q  <= '0;
        gmin_q <= '1;
      end
      OP_G_EV: begin
        if (idx_q != '0 && GapW'(dg) < gmin_q) gmin_q <= GapW'(dg);
        prev_q <= rdm;
        idx_q  <= idx_q + 1'b1;
      end
      OP_G_DEC: begin
        use_w_q <= !(WtW'(gmin_q) > thr_i);
        idx_q   <= '0;
      end
      OP_CSTD: begin
        use_w_q <= 1'b1;
        idx_q   <= '0;
      end
      OP_C_LD0: begin
        cm_q  <= rdm;
        cw_q  <= rdw;
        idx_q <= CW'(1);
        n_q   <= '0;
      end
      OP_C_EV: begin
        em_q  <= rdm;
        ew_q  <= rdw;
        d_q   <= absdiff(rdm, cm_q);
        tot_q <= {1'b0, cw_q} + {1'b0, rdw};
      end
      OP_DIV_START: neg_q <= mac_q[AccW-1];
      OP_C_MRG: begin
        cm_q  <= neg_q ? MeanW'(32'd0 - div_q) : MeanW'(div_q);
        cw_q  <= tot_q[TotW-1] ? '1 : tot_q[WtW-1:0];
        idx_q <= idx_q + 1'b1;
      end
      OP_C_WR: begin
        n_q   <= n_q + 1'b1;
        cm_q  <= em_q;
        cw_q  <= ew_q;
        idx_q <= idx_q + 1'b1;
      end
      OP_I_START: idx_q <= used_q;
      OP_I_SHIFT: idx_q <= idx_q - 1'b1;
      OP_I_PUT:   acc_q <= 1'b1;
      OP_S_START: begin
        idx_q <= '0;
        sum_q <= '0;
      end
      OP_S_EV: begin
        sum_q <= sum_new[WtW] ? '1 : sum_new[WtW-1:0];
        idx_q <= idx_q + 1'b1;
      end
      default: cmd_q <= cmd_q;
    endcase
  end

  always_comb begin
    stat_o.cmd         = cmd_q;
    stat_o.wzero       = wt_q == '0;
    stat_o.used_zero   = used_q == '0;
    stat_o.full        = used_q >= CW'(CAPACITY);
    stat_o.idx_zero    = idx_q == '0;
    stat_o.idx_eq_used = idx_q == used_q;
    stat_o.idx_last    = idx_q == CW'(used_q - 1'b1);
    stat_o.q_hit       = {cum_new, 16'd0} >= CmpW'(tgt_q);
    stat_o.i_ge        = rdm >= val_q;
    stat_o.ok_nw       = GapW'(d_q) <= gmin_q;
    stat_o.ok_w        = (d_q == '0) || (mac_q <= $signed(AccW'(thr_i)));
    stat_o.use_w       = use_w_q;
    stat_o.div_busy    = div_busy;
  end

  assign ans_o  = ans_q;
  assign acc_o  = acc_q;
  assign used_o = used_q;
  assign ws_o   = ws_q;

endmodule

// ----- design/weighted_centroid_quantile_sketch.sv -----
// Top level of the weighted centroid quantile sketch
//
//  channel  | dir | handshake                 | contents
//  s_axis   | in  | s_axis_tvalid/tready      | cmd in tuser; value, weight, percentile
//  m_axis   | out | m_axis_tvalid/tready      | mean, accepted, entries, total weight
//  apb      | in  | psel/penable/pwrite/pready| reg 0 mode at 0, reg 1 threshold at 8
//
// One item at a time; a result waits in an output register while the next item is taken.
// Query: walks the centroids in order. Add: entries are shifted to make room, then a
// weight sum pass runs. In standard and aggressive mode a full table adds a compress
// pass, each merge taking 4 multiply steps and a divider run, with a gap scan first in
// aggressive mode; other modes drop the item when full. No clearing pass after reset.
module weighted_centroid_quantile_sketch import wcqs_pkg::*; #(
  parameter int CAPACITY = CapacityDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [31:0] sample_value, [63:32] sample_weight, [80:64] percentile
  input  logic [InDataW-1:0] s_axis_tdata,
  // [0] cmd
  input  logic               s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [31:0] answer_mean, [32] accepted, [33 +: CW] entries_used, then total_weight
  output logic [((MeanW + 1 + $clog2(CAPACITY + 1) + WtW + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

`include "weighted_centroid_quantile_sketch_assert.svh"

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int OutW  = MeanW + 1 + CW + WtW;
  localparam int OutDW = ((OutW + 7) / 8) * 8;

  logic [ModeW-1:0]        mode_q;
  logic [WtW-1:0]          thr_q;
  logic                    out_valid_q, out_acc_q;
  logic signed [MeanW-1:0] out_ans_q;
  logic [CW-1:0]           out_used_q;
  logic [WtW-1:0]          out_ws_q;

  dp_stat_t                stat;
  dp_op_e                  op;
  logic                    out_load, out_free;
  logic signed [MeanW-1:0] ans;
  logic                    acc;
  logic [CW-1:0]           used;
  logic [WtW-1:0]          ws;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeStd;
      thr_q  <= WtW'(65536);
    end else if (psel && penable && pwrite) begin
      if (paddr[3] == RegThr) begin
        thr_q <= pwdata[WtW-1:0];
      end else begin
        mode_q <= pwdata[ModeW-1:0];
      end
    end
  end

  assign prdata = (paddr[3] == RegMode) ? 64'(mode_q) : 64'(thr_q);
  assign pready = 1'b1;

  assign out_free = !out_valid_q || m_axis_tready;

  wcqs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .out_free_i(out_free),
    .mode_i    (mode_q),
    .stat_i    (stat),
    .s_ready_o (s_axis_tready),
    .out_load_o(out_load),
    .op_o      (op)
  );

  wcqs_dp #(
    .CAPACITY(CAPACITY),
    .CW      (CW)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (op),
    .cmd_i   (s_axis_tuser),
    .value_i (s_axis_tdata[31:0]),
    .weight_i(s_axis_tdata[63:32]),
    .pct_i   (s_axis_tdata[80:64]),
    .thr_i   (thr_q),
    .stat_o  (stat),
    .ans_o   (ans),
    .acc_o   (acc),
    .used_o  (used),
    .ws_o    (ws)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ans_q  <= ans;
      out_acc_q  <= acc;
      out_used_q <= used;
      out_ws_q   <= ws;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDW'({out_ws_q, out_used_q, out_acc_q, out_ans_q});

  `WCQS_ASSERT_NXT(a_busy_after_transfer, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
  `WCQS_ASSERT_IMP(a_add_has_no_mean, out_valid_q && out_acc_q, out_ans_q == '0, "stored add carries a mean")
  `WCQS_ASSERT_IMP(a_used_in_range, out_valid_q, out_used_q <= CW'(CAPACITY), "entry count beyond capacity")

endmodule

// ----- bench/weighted_centroid_quantile_sketch_tb.sv -----
// Self-checking stream testbench for the weighted centroid quantile sketch
`timescale 1ns / 100ps

module weighted_centroid_quantile_sketch_tb import wcqs_pkg::*;;

  localparam int Cap = 64;
  localparam int OutW = 88;
  localparam int Phases = 8;
  localparam int ItemsPerPhase = 92;
  localparam int HoldCycles = 400;
  localparam logic CmdAdd = 1'b0;
  localparam logic CmdQuery = 1'b1;
  localparam logic [ModeW-1:0] ModeNone = 2'd0;
  localparam logic [ModeW-1:0] ModeAlias = 2'd3;
  localparam logic [3:0] AddrMode = 4'd0;
  localparam logic [3:0] AddrThr = 4'd8;
  localparam logic [47:0] WtMax = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic        cmd;
    logic [31:0] val;
    logic [31:0] wt;
    logic [16:0] pct;
  } sketch_item_t;

  typedef struct {
    logic [31:0] mean;
    logic        acc;
    logic [6:0]  used;
    logic [47:0] total;
  } sketch_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  weighted_centroid_quantile_sketch dut (.*);

  always #5 clk_i = ~clk_i;

  // sketch copy kept by the bench
  longint         mdl_mean[Cap];
  logic [63:0]    mdl_wt[Cap];
  int             mdl_used;
  logic [63:0]    mdl_sum;
  logic [ModeW-1:0] mdl_mode;
  logic [47:0]    mdl_thr;

  sketch_item_t   pending_items[$];
  sketch_result_t expected_results[$];
  sketch_item_t   cur_item;
  int regime = 0;
  int hold_left = 0;
  int errors = 0;
  int n_add = 0, n_query = 0, n_drop = 0, n_merge = 0, n_full = 0;
  bit took = 1'b0;
  longint last_val = 0;

  logic [ModeW-1:0] modes[Phases] = '{ModeStd, ModeStd, ModeAggr, ModeNone,
                                      ModeAlias, ModeAggr, ModeStd, ModeAggr};
  logic [47:0] thrs[Phases] = '{48'd65536, 48'd0, 48'd655360, 48'd1234,
                                48'd99, WtMax, WtMax, 48'd0};

  function automatic logic [63:0] dist_of(longint a, longint b);
    return (a >= b) ? 64'(a - b) : 64'(b - a);
  endfunction

  function automatic longint merged_mean(longint m1, logic [63:0] w1, longint m2,
                                         logic [63:0] w2, logic [63:0] tot);
    logic signed [127:0] a, b, num, den;
    a = m1;
    b = m2;
    num = a * $signed({64'd0, w1}) + b * $signed({64'd0, w2});
    den = $signed({64'd0, tot});
    return longint'(num / den);
  endfunction

  function automatic void squeeze_table(bit use_wt, logic [63:0] thr);
    int n;
    longint cm;
    logic [63:0] cw, d, tot;
    bit ok;
    n = 0;
    if (mdl_used < 2) return;
    cm = mdl_mean[0];
    cw = mdl_wt[0];
    for (int i = 1; i < mdl_used; i++) begin
      d = dist_of(mdl_mean[i], cm);
      tot = cw + mdl_wt[i];
      if (use_wt) ok = (d == 0) || (tot <= thr / d);
      else ok = d <= thr;
      if (ok) begin
        cm = merged_mean(cm, cw, mdl_mean[i], mdl_wt[i], tot);
        cw = (tot > {16'd0, WtMax}) ? {16'd0, WtMax} : tot;
        n_merge++;
      end else begin
        mdl_mean[n] = cm;
        mdl_wt[n] = cw;
        n++;
        cm = mdl_mean[i];
        cw = mdl_wt[i];
      end
    end
    mdl_mean[n] = cm;
    mdl_wt[n] = cw;
    mdl_used = n + 1;
  endfunction

  function automatic sketch_result_t predict_sketch(sketch_item_t it);
    sketch_result_t r;
    longint v;
    logic [63:0] g, cum, s;
    logic [127:0] target;
    int pos;
    r.mean = '0;
    r.acc = 1'b0;
    v = longint'($signed(it.val));
    if (it.cmd == CmdQuery) begin
      n_query++;
      if (mdl_used > 0) begin
        target = 128'(mdl_sum) * 128'(it.pct);
        cum = 0;
        r.mean = 32'(mdl_mean[mdl_used-1]);
        for (int i = 0; i + 1 < mdl_used; i++) begin
          cum += mdl_wt[i];
          if ((128'(cum) << 16) >= target) begin
            r.mean = 32'(mdl_mean[i]);
            break;
          end
        end
      end
    end else if (it.wt != 0) begin
      n_add++;
      if (mdl_used >= Cap) begin
        n_full++;
        if (mdl_mode == ModeStd) squeeze_table(1'b1, 64'(mdl_thr));
        else if (mdl_mode == ModeAggr) begin
          g = '1;
          for (int i = 0; i + 1 < mdl_used; i++)
            if (dist_of(mdl_mean[i], mdl_mean[i+1]) < g) g = dist_of(mdl_mean[i], mdl_mean[i+1]);
          if (g > 64'(mdl_thr)) squeeze_table(1'b0, g);
          else squeeze_table(1'b1, 64'(mdl_thr));
        end
      end
      if (mdl_used < Cap) begin
        pos = 0;
        while (pos < mdl_used && mdl_mean[pos] < v) pos++;
        for (int j = mdl_used; j > pos; j--) begin
          mdl_mean[j] = mdl_mean[j-1];
          mdl_wt[j] = mdl_wt[j-1];
        end
        mdl_mean[pos] = v;
        mdl_wt[pos] = 64'(it.wt);
        mdl_used++;
        r.acc = 1'b1;
      end else n_drop++;
      s = 0;
      for (int i = 0; i < mdl_used; i++) begin
        s += mdl_wt[i];
        if (s > {16'd0, WtMax}) s = {16'd0, WtMax};
      end
      mdl_sum = s;
    end
    r.used = 7'(mdl_used);
    r.total = mdl_sum[47:0];
    return r;
  endfunction

  // input side: accept at the rising edge, present the next item at the falling one
  always @(posedge clk_i) begin
    took <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(predict_sketch(cur_item));
    end
  end

  always @(negedge clk_i) begin
    bit gap;
    gap = (regime == 0) ? ($urandom_range(0, 99) < 18) :
          (regime == 1) ? ($urandom_range(0, 99) < 64) : 1'b0;
    if (!s_axis_tvalid || took) begin
      if (pending_items.size() > 0 && !gap && rst_ni) begin
        cur_item = pending_items.pop_front();
        s_axis_tdata <= {7'd0, cur_item.pct, cur_item.wt, cur_item.val};
        s_axis_tuser <= cur_item.cmd;
        s_axis_tvalid <= 1'b1;
      end else s_axis_tvalid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (regime == 0) m_axis_tready <= $urandom_range(0, 99) >= 64;
    else if (regime == 1) m_axis_tready <= $urandom_range(0, 99) >= 18;
    else m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    sketch_result_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (m_axis_tdata[31:0] !== e.mean) begin
          $error("answer_mean: expected %0h got %0h", e.mean, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[32] !== e.acc) begin
          $error("accepted: expected %0d got %0d", e.acc, m_axis_tdata[32]);
          errors++;
        end
        if (m_axis_tdata[39:33] !== e.used) begin
          $error("entries_used: expected %0d got %0d", e.used, m_axis_tdata[39:33]);
          errors++;
        end
        if (m_axis_tdata[87:40] !== e.total) begin
          $error("total_weight: expected %0h got %0h", e.total, m_axis_tdata[87:40]);
          errors++;
        end
      end
    end
  end

  task automatic apb_write(logic [3:0] addr, logic [63:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrMode) mdl_mode = data[ModeW-1:0];
    else if (addr == AddrThr) mdl_thr = data[47:0];
  endtask

  task automatic push_item(logic cmd, logic [31:0] val, logic [31:0] wt, logic [16:0] pct);
    sketch_item_t it;
    it.cmd = cmd;
    it.val = val;
    it.wt = wt;
    it.pct = pct;
    pending_items.push_back(it);
  endtask

  task automatic push_random_item();
    int k;
    logic [31:0] v, w;
    logic [16:0] p;
    k = $urandom_range(0, 99);
    if (k < 70) v = 32'($urandom_range(0, 16383)) - 32'd8192;
    else if (k < 88) v = $urandom;
    else v = 32'(last_val);
    last_val = longint'($signed(v));
    k = $urandom_range(0, 99);
    if (k < 5) w = 0;
    else if (k < 10) w = $urandom;
    else if (k < 18) w = $urandom_range(1, 1 << 20);
    else w = $urandom_range(1, 20);
    k = $urandom_range(0, 99);
    p = (k < 85) ? 17'($urandom_range(0, 65536)) : 17'($urandom_range(0, 131071));
    push_item(($urandom_range(0, 99) < 25) ? CmdQuery : CmdAdd, v, w, p);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    mdl_used = 0;
    mdl_sum = 0;
    mdl_mode = ModeStd;
    mdl_thr = 48'd65536;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, extremes, zero weight, equal means, percentile range
    push_item(CmdQuery, 32'd0, 32'd0, 17'd32768);
    push_item(CmdAdd, 32'd0, 32'd0, 17'd0);
    push_item(CmdAdd, 32'h7FFF_FFFF, 32'd1, 17'd0);
    push_item(CmdAdd, 32'h8000_0000, 32'hFFFF_FFFF, 17'h1FFFF);
    push_item(CmdAdd, 32'd0, 32'd5, 17'd0);
    push_item(CmdAdd, 32'd0, 32'd7, 17'd0);
    push_item(CmdQuery, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd0);
    push_item(CmdQuery, 32'd0, 32'd0, 17'd1);
    push_item(CmdQuery, 32'd0, 32'd0, 17'd32768);
    push_item(CmdQuery, 32'd0, 32'd0, 17'd65536);
    push_item(CmdQuery, 32'd0, 32'd0, 17'h1FFFF);
    push_item(CmdAdd, 32'h0001_0000, 32'd1, 17'd0);
    push_item(CmdQuery, 32'd0, 32'd0, 17'd65535);

    for (int ph = 0; ph < Phases; ph++) begin
      regime = (ph * 3) / Phases;
      wait_drained();
      apb_write(AddrMode, 64'(modes[ph]));
      apb_write(AddrThr, 64'(thrs[ph]));
      for (int i = 0; i < ItemsPerPhase; i++) push_random_item();
      if (ph == 2) begin
        // receiver stalls while the sender keeps offering
        @(posedge clk_i);
        hold_left = HoldCycles;
      end
    end
    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("covered %0d adds, %0d queries; %0d on a full table, %0d merges, %0d dropped",
             n_add, n_query, n_full, n_merge, n_drop);
    if (errors == 0) $display("weighted_centroid_quantile_sketch test passed");
    else $display("weighted_centroid_quantile_sketch test failed");
    $finish;
  end

  initial begin
    #300ms;
    $display("weighted_centroid_quantile_sketch test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/wcqs_pkg.sv
design/wcqs_div.sv
design/wcqs_ctrl.sv
design/wcqs_dp.sv
design/weighted_centroid_quantile_sketch.sv
bench/weighted_centroid_quantile_sketch_tb.sv
